// ===== hw/rtl/cevp_pkg.sv =====
package cevp_pkg;

    // Sensor period handling
    localparam int PERIOD_W    = 16;               // field width on the bus
    localparam int PERIOD_BITS = 16;               // low bits of each period that are used
    localparam int SUM_W       = PERIOD_BITS + 2;  // p0 + p1 + p2
    localparam int WSUM_W      = PERIOD_BITS + 2;  // p1 + 2*p2
    localparam int NUM_W       = PERIOD_BITS + 12; // 1000 * (p1 + 2*p2)
    localparam int CENTER_WEIGHT = 1000;

    // Shared divider
    localparam int DIV_W = (NUM_W > 22) ? NUM_W : 22;
    localparam int QUO_W = 14;
    localparam int CNT_W = 4;

    // Quotient bit counts per division
    localparam int CEN_QBITS  = 11;
    localparam int D_QBITS    = 12;
    localparam int HALF_QBITS = 11;
    localparam int DD_QBITS   = 14;

    // Control law widths
    localparam int POS_W  = 11;
    localparam int DIVR_W = 8;
    localparam int LIM_W  = 15;
    localparam int ERR_W  = 12;
    localparam int D_W    = 13;
    localparam int DD_W   = 16;
    localparam int EFF_W  = 16;
    localparam int TOT_W  = 18;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_REF   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_INTEG = 3'd2;
    localparam logic [IDX_W-1:0] REG_DERIV = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT = 3'd4;

    localparam logic [POS_W-1:0]  REF_RESET   = 11'd1000;
    localparam logic [DIVR_W-1:0] DIVR_RESET  = 8'd1;
    localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd32767;

    // Divider operations
    localparam logic [1:0] OP_CEN   = 2'd0;
    localparam logic [1:0] OP_PROP  = 2'd1;
    localparam logic [1:0] OP_INTEG = 2'd2;
    localparam logic [1:0] OP_DERIV = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  ref_position;
        logic [DIVR_W-1:0] prop_divisor;
        logic [DIVR_W-1:0] integ_divisor;
        logic [DIVR_W-1:0] deriv_divisor;
        logic [LIM_W-1:0]  effort_limit;
    } cevp_cfg_t;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] op;
        logic       cen_take;
        logic       acc;
        logic       sat;
        logic       emit;
    } cevp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic zero_sum;
    } cevp_stat_t;

endpackage

// ===== hw/rtl/cevp_div.sv =====
module cevp_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cevp_pkg::DIV_W-1:0]   num,
    input  logic [cevp_pkg::SUM_W-1:0]   den,
    input  logic [cevp_pkg::CNT_W-1:0]   last_bit,
    output logic                         done,
    output logic [cevp_pkg::QUO_W-1:0]   quo
);

    logic [cevp_pkg::DIV_W-1:0] rem_reg;
    logic [cevp_pkg::DIV_W-1:0] den_sh_reg;
    logic [cevp_pkg::QUO_W-1:0] quo_reg;
    logic [cevp_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       fits;

    assign fits = (rem_reg >= den_sh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // One quotient bit per cycle, divisor aligned to the top quotient bit
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg    <= num;
            den_sh_reg <= cevp_pkg::DIV_W'(den) << last_bit;
            quo_reg    <= '0;
            cnt_reg    <= last_bit;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - den_sh_reg;
            end
            quo_reg    <= {quo_reg[cevp_pkg::QUO_W-2:0], fits};
            den_sh_reg <= den_sh_reg >> 1;
            cnt_reg    <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/cevp_dp.sv =====
module cevp_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cevp_pkg::cevp_cmd_t             cmd,
    input  cevp_pkg::cevp_cfg_t             cfg,
    input  logic [cevp_pkg::PERIOD_W-1:0]   in_period_0,
    input  logic [cevp_pkg::PERIOD_W-1:0]   in_period_1,
    input  logic [cevp_pkg::PERIOD_W-1:0]   in_period_2,
    input  logic                            in_clear_effort,
    output cevp_pkg::cevp_stat_t            stat,
    output logic [cevp_pkg::EFF_W-1:0]      effort,
    output logic                            zero_sum
);

    function automatic logic [cevp_pkg::DIVR_W-1:0] div_or_one(
        input logic [cevp_pkg::DIVR_W-1:0] x
    );
        return (x == '0) ? cevp_pkg::DIVR_W'(1) : x;
    endfunction

    logic [cevp_pkg::PERIOD_BITS-1:0] p0m, p1m, p2m;
    logic [cevp_pkg::WSUM_W-1:0]      wsum;

    logic [cevp_pkg::SUM_W-1:0]  sum_reg;
    logic [cevp_pkg::NUM_W-1:0]  num_reg;
    logic                        clr_reg;
    logic                        neg_reg;

    logic signed [cevp_pkg::ERR_W-1:0] e0_reg, e1_reg, e2_reg;
    logic signed [cevp_pkg::EFF_W-1:0] prior_reg;
    logic signed [cevp_pkg::TOT_W-1:0] total_reg;

    logic signed [cevp_pkg::D_W-1:0]  d;
    logic        [cevp_pkg::D_W-1:0]  d_mag;
    logic        [cevp_pkg::D_W-1:0]  half_mag;
    logic signed [cevp_pkg::DD_W-1:0] dd2;
    logic        [cevp_pkg::DD_W-1:0] dd_mag;

    logic [cevp_pkg::DIV_W-1:0] div_num;
    logic [cevp_pkg::SUM_W-1:0] div_den;
    logic [cevp_pkg::CNT_W-1:0] div_last;
    logic                       sel_neg;
    logic                       div_done;
    logic [cevp_pkg::QUO_W-1:0] quo;

    logic        [cevp_pkg::POS_W-1:0]  centroid;
    logic signed [cevp_pkg::ERR_W-1:0]  e_new;
    logic signed [cevp_pkg::TOT_W-1:0]  quo_s;
    logic signed [cevp_pkg::TOT_W-1:0]  lim_s;
    logic                               zero_now;

    assign p0m  = in_period_0[cevp_pkg::PERIOD_BITS-1:0];
    assign p1m  = in_period_1[cevp_pkg::PERIOD_BITS-1:0];
    assign p2m  = in_period_2[cevp_pkg::PERIOD_BITS-1:0];
    assign wsum = cevp_pkg::WSUM_W'(p1m) + (cevp_pkg::WSUM_W'(p2m) << 1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sum_reg <= cevp_pkg::SUM_W'(p0m) + cevp_pkg::SUM_W'(p1m)
                       + cevp_pkg::SUM_W'(p2m);
            num_reg <= cevp_pkg::NUM_W'(wsum)
                       * cevp_pkg::NUM_W'(cevp_pkg::CENTER_WEIGHT);
            clr_reg <= in_clear_effort;
        end
    end

    assign zero_now = (sum_reg == '0);

    // Error differences
    assign d        = cevp_pkg::D_W'(e0_reg) - cevp_pkg::D_W'(e1_reg);
    assign d_mag    = d[cevp_pkg::D_W-1] ? cevp_pkg::D_W'(-d) : cevp_pkg::D_W'(d);
    assign half_mag = d_mag >> 1;
    assign dd2      = (cevp_pkg::DD_W'(e0_reg) <<< 1) - (cevp_pkg::DD_W'(e1_reg) <<< 2)
                      + (cevp_pkg::DD_W'(e2_reg) <<< 1);
    assign dd_mag   = dd2[cevp_pkg::DD_W-1] ? cevp_pkg::DD_W'(-dd2)
                                            : cevp_pkg::DD_W'(dd2);

    always_comb begin
        case (cmd.op)
            cevp_pkg::OP_CEN: begin
                div_num  = cevp_pkg::DIV_W'(num_reg);
                div_den  = sum_reg;
                div_last = cevp_pkg::CNT_W'(cevp_pkg::CEN_QBITS - 1);
                sel_neg  = 1'b0;
            end
            cevp_pkg::OP_PROP: begin
                div_num  = cevp_pkg::DIV_W'(d_mag);
                div_den  = cevp_pkg::SUM_W'(div_or_one(cfg.prop_divisor));
                div_last = cevp_pkg::CNT_W'(cevp_pkg::D_QBITS - 1);
                sel_neg  = d[cevp_pkg::D_W-1];
            end
            cevp_pkg::OP_INTEG: begin
                div_num  = cevp_pkg::DIV_W'(half_mag);
                div_den  = cevp_pkg::SUM_W'(div_or_one(cfg.integ_divisor));
                div_last = cevp_pkg::CNT_W'(cevp_pkg::HALF_QBITS - 1);
                sel_neg  = d[cevp_pkg::D_W-1];
            end
            default: begin
                div_num  = cevp_pkg::DIV_W'(dd_mag);
                div_den  = cevp_pkg::SUM_W'(div_or_one(cfg.deriv_divisor));
                div_last = cevp_pkg::CNT_W'(cevp_pkg::DD_QBITS - 1);
                sel_neg  = dd2[cevp_pkg::DD_W-1];
            end
        endcase
    end

    cevp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .last_bit (div_last),
        .done     (div_done),
        .quo      (quo)
    );

    assign centroid = zero_now ? '0 : quo[cevp_pkg::POS_W-1:0];
    assign e_new    = cevp_pkg::ERR_W'({1'b0, centroid})
                      - cevp_pkg::ERR_W'({1'b0, cfg.ref_position});
    assign quo_s    = neg_reg ? -cevp_pkg::TOT_W'(quo) : cevp_pkg::TOT_W'(quo);
    assign lim_s    = cevp_pkg::TOT_W'(cfg.effort_limit);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= sel_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_reg    <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
            prior_reg <= '0;
            total_reg <= '0;
        end else begin
            if (cmd.cen_take) begin
                e2_reg    <= e1_reg;
                e1_reg    <= e0_reg;
                e0_reg    <= e_new;
                total_reg <= clr_reg ? '0 : cevp_pkg::TOT_W'(prior_reg);
            end else if (cmd.acc) begin
                total_reg <= total_reg + quo_s;
            end
            // Saturate the new effort and keep it
            if (cmd.sat) begin
                if (total_reg > lim_s) begin
                    prior_reg <= lim_s[cevp_pkg::EFF_W-1:0];
                end else if (total_reg < -lim_s) begin
                    prior_reg <= cevp_pkg::EFF_W'(-lim_s);
                end else begin
                    prior_reg <= total_reg[cevp_pkg::EFF_W-1:0];
                end
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.zero_sum = zero_now;
    assign effort        = prior_reg;
    assign zero_sum      = zero_now;

endmodule

// ===== hw/rtl/cevp_ctrl.sv =====
module cevp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  out_free,
    input  cevp_pkg::cevp_stat_t  stat,
    output logic                  in_ready,
    output cevp_pkg::cevp_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CEN      = 4'd1;
    localparam logic [3:0] S_CEN_WAIT = 4'd2;
    localparam logic [3:0] S_P        = 4'd3;
    localparam logic [3:0] S_P_WAIT   = 4'd4;
    localparam logic [3:0] S_I        = 4'd5;
    localparam logic [3:0] S_I_WAIT   = 4'd6;
    localparam logic [3:0] S_D        = 4'd7;
    localparam logic [3:0] S_D_WAIT   = 4'd8;
    localparam logic [3:0] S_SAT      = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CEN;
                end
            end
            S_CEN: begin
                cmd.op = cevp_pkg::OP_CEN;
                // No divide when all periods are zero
                if (stat.zero_sum) begin
                    cmd.cen_take = 1'b1;
                    state_next   = S_P;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_CEN_WAIT;
                end
            end
            S_CEN_WAIT: begin
                cmd.op = cevp_pkg::OP_CEN;
                if (stat.div_done) begin
                    cmd.cen_take = 1'b1;
                    state_next   = S_P;
                end
            end
            S_P: begin
                cmd.op        = cevp_pkg::OP_PROP;
                cmd.div_start = 1'b1;
                state_next    = S_P_WAIT;
            end
            S_P_WAIT: begin
                cmd.op = cevp_pkg::OP_PROP;
                if (stat.div_done) begin
                    cmd.acc    = 1'b1;
                    state_next = S_I;
                end
            end
            S_I: begin
                cmd.op        = cevp_pkg::OP_INTEG;
                cmd.div_start = 1'b1;
                state_next    = S_I_WAIT;
            end
            S_I_WAIT: begin
                cmd.op = cevp_pkg::OP_INTEG;
                if (stat.div_done) begin
                    cmd.acc    = 1'b1;
                    state_next = S_D;
                end
            end
            S_D: begin
                cmd.op        = cevp_pkg::OP_DERIV;
                cmd.div_start = 1'b1;
                state_next    = S_D_WAIT;
            end
            S_D_WAIT: begin
                cmd.op = cevp_pkg::OP_DERIV;
                if (stat.div_done) begin
                    cmd.acc    = 1'b1;
                    state_next = S_SAT;
                end
            end
            S_SAT: begin
                cmd.sat    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register can take the item
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/centroid_error_velocity_pid_core.sv =====
// Channel   Dir  Handshake        Payload
// s_        in   tvalid/tready    tdata: period_0, period_1, period_2; tuser: clear_effort
// m_        out  tvalid/tready    tdata: effort; tuser: zero_sum
// config    in   APB psel/penable ref_position, prop/integ/deriv_divisor, effort_limit
//
// An accepted item is loaded, then passes through four divisions on the single shared
// divider (centroid, proportional, integral, derivative), a saturate step and an emit
// step; the centroid division is skipped when the period sum is zero. The divider
// retires one quotient bit per cycle (11 + 12 + 11 + 14 bits). The next item is
// accepted only after the previous result has been emitted. Reset is synchronous, active
// low, and restores the register defaults, the error history and the kept effort. A new
// item is taken while a result waits in the output register; a stalled m_ side holds
// the block.
module centroid_error_velocity_pid_core (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // period_0, period_1, period_2
    input  logic [0:0]                     s_tuser,   // clear_effort

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // effort
    output logic [0:0]                     m_tuser,   // zero_sum

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cevp_pkg::ADDR_W-1:0]    paddr,
    input  logic [cevp_pkg::DATA_W-1:0]    pwdata,
    output logic [cevp_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    cevp_pkg::cevp_cfg_t  cfg_reg;
    cevp_pkg::cevp_cmd_t  cmd;
    cevp_pkg::cevp_stat_t stat;

    logic [cevp_pkg::IDX_W-1:0] reg_idx;
    logic                       cfg_write;
    logic                       out_free;
    logic [cevp_pkg::EFF_W-1:0] effort;
    logic                       zero_sum;

    logic                       m_tvalid_reg;
    logic [cevp_pkg::EFF_W-1:0] m_effort_reg;
    logic                       m_zero_reg;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[cevp_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ref_position  <= cevp_pkg::REF_RESET;
            cfg_reg.prop_divisor  <= cevp_pkg::DIVR_RESET;
            cfg_reg.integ_divisor <= cevp_pkg::DIVR_RESET;
            cfg_reg.deriv_divisor <= cevp_pkg::DIVR_RESET;
            cfg_reg.effort_limit  <= cevp_pkg::LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                cevp_pkg::REG_REF:   cfg_reg.ref_position  <= pwdata[cevp_pkg::POS_W-1:0];
                cevp_pkg::REG_PROP:  cfg_reg.prop_divisor  <= pwdata[cevp_pkg::DIVR_W-1:0];
                cevp_pkg::REG_INTEG: cfg_reg.integ_divisor <= pwdata[cevp_pkg::DIVR_W-1:0];
                cevp_pkg::REG_DERIV: cfg_reg.deriv_divisor <= pwdata[cevp_pkg::DIVR_W-1:0];
                cevp_pkg::REG_LIMIT: cfg_reg.effort_limit  <= pwdata[cevp_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cevp_pkg::REG_REF:   prdata = cevp_pkg::DATA_W'(cfg_reg.ref_position);
            cevp_pkg::REG_PROP:  prdata = cevp_pkg::DATA_W'(cfg_reg.prop_divisor);
            cevp_pkg::REG_INTEG: prdata = cevp_pkg::DATA_W'(cfg_reg.integ_divisor);
            cevp_pkg::REG_DERIV: prdata = cevp_pkg::DATA_W'(cfg_reg.deriv_divisor);
            cevp_pkg::REG_LIMIT: prdata = cevp_pkg::DATA_W'(cfg_reg.effort_limit);
            default:             prdata = '0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    cevp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    cevp_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg             (cfg_reg),
        .in_period_0     (s_tdata[15:0]),
        .in_period_1     (s_tdata[31:16]),
        .in_period_2     (s_tdata[47:32]),
        .in_clear_effort (s_tuser[0]),
        .stat            (stat),
        .effort          (effort),
        .zero_sum        (zero_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_effort_reg <= effort;
            m_zero_reg   <= zero_sum;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_effort_reg;
    assign m_tuser[0] = m_zero_reg;

endmodule

// ===== tb/tb_centroid_error_velocity_pid_core.sv =====
`timescale 1ns / 1ps

module tb_centroid_error_velocity_pid_core;

    localparam int CENTER_WEIGHT_TB = 1000;
    localparam int FAR_WEIGHT_TB    = 2000;
    localparam int UNMAPPED_REG     = 5;
    localparam int ITEM_LATENCY     = 60;
    localparam int LONG_HOLD        = 400;
    localparam int PHASE_ITEMS      = 200;
    localparam int NUM_PHASES       = 8;

    typedef struct {
        logic [15:0] p0;
        logic [15:0] p1;
        logic [15:0] p2;
        logic        clr;
    } sensor_reading_t;

    typedef struct {
        logic [15:0] effort;
        logic        zero_sum;
    } pid_out_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;    // period_0, period_1, period_2
    logic [0:0]  s_tuser  = '0;    // clear_effort
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // effort
    logic [0:0]  m_tuser;          // zero_sum
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [cevp_pkg::ADDR_W-1:0] paddr  = '0;
    logic [cevp_pkg::DATA_W-1:0] pwdata = '0;
    logic [cevp_pkg::DATA_W-1:0] prdata;
    logic        pready;

    centroid_error_velocity_pid_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // predictor state
    cevp_pkg::cevp_cfg_t pid_cfg = '{cevp_pkg::REF_RESET, cevp_pkg::DIVR_RESET,
                                     cevp_pkg::DIVR_RESET, cevp_pkg::DIVR_RESET,
                                     cevp_pkg::LIMIT_RESET};
    int        err_hist [3] = '{0, 0, 0};
    int        kept_effort = 0;

    sensor_reading_t readings_to_send [$];
    pid_out_t        efforts_due [$];
    int  n_queued      = 0;
    int  n_accepted    = 0;
    int  errors        = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  s_took        = 1'b0;
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;

    function automatic int divisor_of(logic [cevp_pkg::DIVR_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic pid_out_t predict_effort(sensor_reading_t r);
        longint   sum;
        int       cen;
        int       d;
        int       dd;
        int       total;
        int       lim;
        pid_out_t res;
        sum = longint'(r.p0) + longint'(r.p1) + longint'(r.p2);
        res.zero_sum = (sum == 0);
        cen = res.zero_sum ? 0 :
              int'((CENTER_WEIGHT_TB * longint'(r.p1) + FAR_WEIGHT_TB * longint'(r.p2)) / sum);
        err_hist[2] = err_hist[1];
        err_hist[1] = err_hist[0];
        err_hist[0] = cen - int'(pid_cfg.ref_position);
        if (r.clr)
            kept_effort = 0;
        d  = err_hist[0] - err_hist[1];
        dd = err_hist[0] - 2 * err_hist[1] + err_hist[2];
        total = kept_effort + d / divisor_of(pid_cfg.prop_divisor)
              + (d / 2) / divisor_of(pid_cfg.integ_divisor)
              + (2 * dd) / divisor_of(pid_cfg.deriv_divisor);
        lim = int'(pid_cfg.effort_limit);
        if (total > lim)
            total = lim;
        else if (total < -lim)
            total = -lim;
        kept_effort = total;
        res.effort = total[15:0];
        return res;
    endfunction

    // register write; upper bits of the bus carry junk now and then
    task automatic apb_write(int idx, logic [15:0] value);
        logic [cevp_pkg::DATA_W-1:0] word;
        word = {($urandom_range(3) == 0) ? 16'($urandom()) : 16'h0, value};
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = cevp_pkg::ADDR_W'(idx * 4);
        pwdata  = word;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            cevp_pkg::REG_REF:   pid_cfg.ref_position  = word[cevp_pkg::POS_W-1:0];
            cevp_pkg::REG_PROP:  pid_cfg.prop_divisor  = word[cevp_pkg::DIVR_W-1:0];
            cevp_pkg::REG_INTEG: pid_cfg.integ_divisor = word[cevp_pkg::DIVR_W-1:0];
            cevp_pkg::REG_DERIV: pid_cfg.deriv_divisor = word[cevp_pkg::DIVR_W-1:0];
            cevp_pkg::REG_LIMIT: pid_cfg.effort_limit  = word[cevp_pkg::LIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_gains(int ref_pos, int kp, int ki, int kd, int lim);
        apb_write(cevp_pkg::REG_REF, 16'(ref_pos));
        apb_write(cevp_pkg::REG_PROP, 16'(kp));
        apb_write(cevp_pkg::REG_INTEG, 16'(ki));
        apb_write(cevp_pkg::REG_DERIV, 16'(kd));
        apb_write(cevp_pkg::REG_LIMIT, 16'(lim));
    endtask

    task automatic add_reading(logic [15:0] p0, logic [15:0] p1, logic [15:0] p2, logic clr);
        sensor_reading_t r;
        r.p0  = p0;
        r.p1  = p1;
        r.p2  = p2;
        r.clr = clr;
        readings_to_send.push_back(r);
        n_queued++;
    endtask

    task automatic add_random_reading();
        int   kind;
        int   hot;
        logic clr;
        kind = $urandom_range(99);
        clr  = ($urandom_range(99) < 8);
        if (kind < 8) begin
            add_reading(16'h0, 16'h0, 16'h0, clr);
        end else if (kind < 22) begin
            hot = $urandom_range(2);
            add_reading((hot == 0) ? 16'($urandom()) : 16'h0,
                        (hot == 1) ? 16'($urandom()) : 16'h0,
                        (hot == 2) ? 16'($urandom()) : 16'h0, clr);
        end else if (kind < 38) begin
            add_reading(16'($urandom_range(15)), 16'($urandom_range(15)),
                        16'($urandom_range(15)), clr);
        end else begin
            add_reading(16'($urandom()), 16'($urandom()), 16'($urandom()), clr);
        end
    endtask

    // hold until every queued item has been accepted and answered
    task automatic wait_drained();
        while (n_accepted != n_queued || efforts_due.size() != 0)
            @(posedge aclk);
        repeat (ITEM_LATENCY) @(posedge aclk);
    endtask

    // sender
    always @(negedge aclk) begin : drive_input
        sensor_reading_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (readings_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = readings_to_send.pop_front();
                s_tdata  <= {nxt.p2, nxt.p1, nxt.p0};
                s_tuser  <= nxt.clr;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sample both channels, predict on accept, check on delivery
    always @(posedge aclk) begin : watch
        sensor_reading_t got_in;
        pid_out_t        want;
        if (!aresetn) begin
            s_took = 1'b0;
        end else begin
            s_took = s_tvalid && s_tready;
            if (s_took) begin
                got_in.p0  = s_tdata[15:0];
                got_in.p1  = s_tdata[31:16];
                got_in.p2  = s_tdata[47:32];
                got_in.clr = s_tuser[0];
                efforts_due.push_back(predict_effort(got_in));
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (efforts_due.size() == 0) begin
                    $display("%0t: unexpected result effort %0d zero_sum %0d",
                             $time, $signed(m_tdata), m_tuser);
                    errors++;
                end else begin
                    want = efforts_due.pop_front();
                    if (m_tdata !== want.effort) begin
                        $display("%0t: effort mismatch, expected %0d got %0d",
                                 $time, $signed(want.effort), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser[0] !== want.zero_sum) begin
                        $display("%0t: zero_sum mismatch, expected %0d got %0d",
                                 $time, want.zero_sum, m_tuser[0]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #8ms;
        $display("tb_centroid_error_velocity_pid_core failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase

            case (ph)
                0: ;    // reset values
                1: write_gains(0, 255, 255, 255, 32767);
                2: write_gains(2047, 0, 0, 0, 0);
                3: begin
                    write_gains(2000, 1, 1, 1, 1);
                    apb_write(UNMAPPED_REG, 16'h1234);
                end
                5: write_gains(1000, 2, 3, 4, 1000);
                7: write_gains($urandom_range(2047), $urandom_range(1, 8),
                               $urandom_range(1, 8), $urandom_range(1, 8),
                               $urandom_range(1, 200));
                default: write_gains($urandom_range(2047), $urandom_range(255),
                                     $urandom_range(255), $urandom_range(255),
                                     $urandom_range(32767));
            endcase

            if (ph == 0) begin
                add_reading(16'h0000, 16'h0000, 16'h0000, 1'b0);
                add_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                add_reading(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
                add_reading(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
                add_reading(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
                add_reading(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
                add_reading(16'h0000, 16'h0000, 16'h0001, 1'b0);
                add_reading(16'h0001, 16'h0000, 16'h0000, 1'b1);
                add_reading(16'h0000, 16'h0001, 16'h0001, 1'b0);
                add_reading(16'h0001, 16'h0001, 16'h0001, 1'b0);
                add_reading(16'h0000, 16'h0000, 16'h0000, 1'b1);
                add_reading(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
                add_reading(16'h0001, 16'h0000, 16'hFFFF, 1'b0);
                add_reading(16'hFFFF, 16'h0001, 16'h0000, 1'b0);
                add_reading(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
                add_reading(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
                // swing hard between the edges to push the effort to its limit
                for (int k = 0; k < 4; k++) begin
                    add_reading(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
                    add_reading(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
                end
            end

            for (int k = 0; k < PHASE_ITEMS; k++)
                add_random_reading();

            if (ph == 4)
                hold_req = 1'b1;

            wait_drained();
        end

        if (errors == 0)
            $display("tb_centroid_error_velocity_pid_core passed");
        else
            $display("tb_centroid_error_velocity_pid_core failed");
        $finish;
    end

endmodule
